>>> hw/rtl/selective_repeat_sender_window_unit_macros.svh
// ----------------------------------------------------------------------------
// Selective-repeat sender window: assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_UNIT_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_UNIT_MACROS_SVH

// Plain property check.
`define SRSW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition in a cycle implies a consequence in the next.
`define SRSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  `SRSW_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

>>> hw/rtl/srsw_pkg.sv
// ----------------------------------------------------------------------------
// Selective-repeat sender window package
// Field widths, register indexes and the slot record moved along the row.
// ----------------------------------------------------------------------------
package srsw_pkg;

  localparam int FrameNumW = 16;
  localparam int CountW    = 32;
  localparam int TotalW    = 16;
  localparam int WinCfgW   = 4;
  localparam int AckW      = 8;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] RegTotalFrames = 1'b0;
  localparam logic [CfgIdxW-1:0] RegWindowSize  = 1'b1;

  // One window slot waiting to be sent.
  typedef struct packed {
    logic                 pend;
    logic                 last;
    logic                 done;
    logic [FrameNumW-1:0] frame;
  } slot_t;

endpackage

>>> hw/rtl/srsw_slot.sv
// ----------------------------------------------------------------------------
// Send slot
// One stage of the send row: loads a slot at round start, otherwise takes
// its upper neighbor's slot whenever the row advances.
// ----------------------------------------------------------------------------
module srsw_slot (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic            shift_i,
  input  srsw_pkg::slot_t load_slot_i,
  input  srsw_pkg::slot_t next_slot_i,
  output srsw_pkg::slot_t slot_o
);
  import srsw_pkg::*;

  slot_t slot_d, slot_q;

  always_comb begin
    slot_d = slot_q;
    if (load_i) begin
      slot_d = load_slot_i;
    end else if (shift_i) begin
      slot_d = next_slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

>>> hw/rtl/srsw_window.sv
// ----------------------------------------------------------------------------
// Window state
// Holds the window base and the ack bitmap relative to it. Builds the send
// row for a round and, on a round start, applies the ack mask and slides.
// ----------------------------------------------------------------------------
module srsw_window #(
  parameter int MAX_WINDOW = 8,
  parameter int FRAME_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [srsw_pkg::TotalW-1:0]  total_frames_i,
  input  logic [srsw_pkg::WinCfgW-1:0] window_size_i,
  input  logic [srsw_pkg::AckW-1:0]    ack_mask_i,
  input  logic                         step_i,
  output srsw_pkg::slot_t              load_o [MAX_WINDOW]
);
  import srsw_pkg::*;

  localparam int NW = $clog2(MAX_WINDOW + 1);
  localparam int EW = (NW > WinCfgW) ? NW : WinCfgW;
  localparam int CW = (FRAME_BITS > TotalW) ? FRAME_BITS : TotalW;

  logic [FRAME_BITS-1:0]           base_q, base_d;
  logic [MAX_WINDOW-1:0]           acked_q, acked_d;
  logic [MAX_WINDOW-1:0]           in_win, mask_w, comb, pend;
  logic [MAX_WINDOW+AckW-1:0]      mask_x;
  logic [EW-1:0]                   ws_x;
  logic [NW-1:0]                   win, n, slide;
  logic [CW-1:0]                   base_x, total_x, diff;
  logic                            done;
  logic [FRAME_BITS-1:0]           fr   [MAX_WINDOW];
  logic [FRAME_BITS+FrameNumW-1:0] fr_x [MAX_WINDOW];

  always_comb begin
    // clamp window size to 1..MAX_WINDOW
    ws_x = EW'(window_size_i);
    if (ws_x == '0) begin
      win = NW'(1);
    end else if (ws_x > EW'(MAX_WINDOW)) begin
      win = NW'(MAX_WINDOW);
    end else begin
      win = NW'(ws_x);
    end

    base_x  = CW'(base_q);
    total_x = CW'(total_frames_i);
    done    = (base_x >= total_x);
    diff    = total_x - base_x;
    n       = (diff < CW'(win)) ? NW'(diff) : win;

    mask_x = (MAX_WINDOW + AckW)'(ack_mask_i);
    mask_w = mask_x[MAX_WINDOW-1:0];
    for (int j = 0; j < MAX_WINDOW; j++) begin
      in_win[j] = (j < int'(n));
    end
    comb = acked_q | (mask_w & in_win);
    pend = in_win & ~acked_q;

    // first frame still unacked after this round, else whole window
    slide = n;
    for (int j = MAX_WINDOW - 1; j >= 0; j--) begin
      if (in_win[j] && !comb[j]) begin
        slide = NW'(j);
      end
    end

    acked_d = acked_q;
    base_d  = base_q;
    if (step_i && !done) begin
      acked_d = comb >> slide;
      base_d  = base_q + FRAME_BITS'(slide);
    end

    for (int j = 0; j < MAX_WINDOW; j++) begin
      fr[j]           = base_q + FRAME_BITS'(j);
      fr_x[j]         = (FRAME_BITS + FrameNumW)'(fr[j]);
      load_o[j].pend  = pend[j];
      load_o[j].last  = pend[j] & ((pend >> (j + 1)) == '0);
      load_o[j].done  = 1'b0;
      load_o[j].frame = fr_x[j][FrameNumW-1:0];
    end
    if (done) begin
      for (int j = 0; j < MAX_WINDOW; j++) begin
        load_o[j] = '0;
      end
      load_o[0].pend = 1'b1;
      load_o[0].last = 1'b1;
      load_o[0].done = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      acked_q <= '0;
    end else begin
      base_q  <= base_d;
      acked_q <= acked_d;
    end
  end

endmodule

>>> hw/rtl/selective_repeat_sender_window_unit.sv
// ----------------------------------------------------------------------------
// Selective-repeat sender window unit
// Channel  Dir  Payload (low bit first)                     Transfer when
// cfg      in   cfg_addr_i index, cfg_wdata_i value           cfg_we_i high
// s_axis   in   tdata: ack_mask[7:0]                          tvalid & tready
// m_axis   out  tdata: frame_number[15:0], total_sent[31:0]   tvalid & tready
//               tlast: last, tuser: done_res
// A round loads the send row with at most window_size pending slots (8 by
// default); the row moves one slot per cycle unless m_axis stalls it, and a
// round holds it until its last pending slot leaves. A done round is one slot.
// The next round is taken in the cycle the current round's last result
// leaves the row; one output register decouples the row from m_axis stalls.
// Reset: total_frames = 1, window_size = 8, base, bitmap and count zero.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window_unit #(
  parameter int MAX_WINDOW = 8,
  parameter int FRAME_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [srsw_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  logic [srsw_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // ack_mask[7:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [47:0]                   m_axis_tdata,  // frame_number[15:0], total_sent[47:16]
  output logic                          m_axis_tlast,
  output logic [0:0]                    m_axis_tuser   // done_res
);
  import srsw_pkg::*;

  logic [TotalW-1:0]    total_q, total_d;
  logic [WinCfgW-1:0]   wsize_q, wsize_d;
  logic [CountW-1:0]    sent_q, sent_d;
  logic                 out_valid_q, out_valid_d;
  logic [FrameNumW-1:0] out_frame_q;
  logic                 out_last_q, out_done_q;
  logic [CountW-1:0]    out_count_q;

  slot_t                load_slot [MAX_WINDOW];
  slot_t                row       [MAX_WINDOW];
  slot_t                nxt       [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] pend_row;
  logic                 move, shift, accept;

  // configuration writes
  always_comb begin
    total_d = total_q;
    wsize_d = wsize_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegTotalFrames: total_d = cfg_wdata_i[TotalW-1:0];
        RegWindowSize:  wsize_d = cfg_wdata_i[WinCfgW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TotalW'(1);
      wsize_q <= WinCfgW'(8);
    end else begin
      total_q <= total_d;
      wsize_q <= wsize_d;
    end
  end

  srsw_window #(
    .MAX_WINDOW(MAX_WINDOW),
    .FRAME_BITS(FRAME_BITS)
  ) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .total_frames_i(total_q),
    .window_size_i (wsize_q),
    .ack_mask_i    (s_axis_tdata),
    .step_i        (accept),
    .load_o        (load_slot)
  );

  // send row, slot 0 at the head
  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_row
    if (g == MAX_WINDOW - 1) begin : g_top
      assign nxt[g] = '0;
    end else begin : g_mid
      assign nxt[g] = row[g+1];
    end
    assign pend_row[g] = row[g].pend;

    srsw_slot u_slot (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_i     (accept),
      .shift_i    (shift),
      .load_slot_i(load_slot[g]),
      .next_slot_i(nxt[g]),
      .slot_o     (row[g])
    );
  end

  assign move          = row[0].pend && (!out_valid_q || m_axis_tready);
  assign shift         = !row[0].pend || move;
  assign s_axis_tready = ((pend_row >> 1) == '0) && (!row[0].pend || move);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    sent_d      = sent_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (move) begin
      out_valid_d = 1'b1;
      if (!row[0].done) begin
        sent_d = sent_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sent_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      sent_q      <= sent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_frame_q <= row[0].frame;
      out_last_q  <= row[0].last;
      out_done_q  <= row[0].done;
      out_count_q <= sent_d;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = {out_count_q, out_frame_q};
  assign m_axis_tlast    = out_last_q;
  assign m_axis_tuser[0] = out_done_q;

endmodule

>>> hw/rtl/srsw_checker.sv
// ----------------------------------------------------------------------------
// Selective-repeat sender window checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "selective_repeat_sender_window_unit_macros.svh"

module srsw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [0:0]  m_axis_tuser
);

  // stalled result must hold
  `SRSW_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  // a done result is a round of its own with frame zero
  `SRSW_ASSERT(a_done_form, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata[15:0] == 16'd0, "malformed done result")

  // no new round while the current one still has results queued behind a stall
  `SRSW_ASSERT(a_round_order, m_axis_tvalid && !m_axis_tlast && !m_axis_tready |-> !s_axis_tready, "round taken before previous round drained")

endmodule

bind selective_repeat_sender_window_unit srsw_checker u_srsw_checker (.*);
